>>> rtl/cldf_pkg.sv
package cldf_pkg;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EARLY_END  = 3'd1;
	localparam logic [2:0] ERR_NAME_CHAR  = 3'd2;
	localparam logic [2:0] ERR_VALUE_LF   = 3'd3;
	localparam logic [2:0] ERR_BLANK_LF   = 3'd4;
	localparam logic [2:0] ERR_NO_LENGTH  = 3'd5;
	localparam logic [2:0] ERR_UNKNOWN    = 3'd6;

	// characters
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DASH  = 8'h2D;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_VT    = 8'h0B;
	localparam logic [7:0] CHR_FF    = 8'h0C;

	// header name lengths
	localparam logic [3:0] LENGTH_NAME_LEN = 4'd14;
	localparam logic [3:0] TYPE_NAME_LEN   = 4'd12;
	localparam logic [3:0] NAME_POS_MAX    = 4'd15;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// byte classes worked out by the front end
	typedef struct packed {
		logic letter;
		logic name_char;
		logic digit;
		logic blank;
		logic cr;
		logic lf;
		logic colon;
		logic space;
		logic plus;
		logic minus;
	} cldf_class_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        end_of_input;
		cldf_class_t cls;
	} cldf_token_t;

	// "Content-Length", one character per position
	function automatic logic [7:0] length_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "Content-Type", one character per position
	function automatic logic [7:0] type_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "T";
			4'd9:    c = "y";
			4'd10:   c = "p";
			4'd11:   c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/cldf_ifs.sv
// stream of input bytes
interface cldf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

// stream of deframed results
interface cldf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic       last_of_message;
	logic [2:0] error_code;

	modport source (output valid, output kind, output payload_byte,
		output last_of_message, output error_code, input ready);
	modport sink (input valid, input kind, input payload_byte,
		input last_of_message, input error_code, output ready);
endinterface

>>> rtl/cldf_front.sv
module cldf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	cldf_in_if.sink              stream,
	output cldf_pkg::cldf_token_t tok_s1,
	output logic                 tok_valid_s1,
	input  logic                 push_ready
);
	import cldf_pkg::*;

	cldf_class_t cls;
	logic [7:0]  b;
	logic        take;

	// classify the incoming byte
	always_comb begin
		b = stream.data_byte;
		cls.letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
		cls.name_char = cls.letter || b == CHR_DASH;
		cls.digit = b >= "0" && b <= "9";
		cls.blank = b == CHR_SPACE || b == CHR_TAB || b == CHR_LF || b == CHR_VT
			|| b == CHR_FF;
		cls.cr = b == CHR_CR;
		cls.lf = b == CHR_LF;
		cls.colon = b == CHR_COLON;
		cls.space = b == CHR_SPACE;
		cls.plus = b == CHR_PLUS;
		cls.minus = b == CHR_DASH;
	end

	assign stream.ready = !tok_valid_s1 || push_ready;
	assign take = stream.valid && stream.ready;

	// hold the classified token until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (take) begin
			tok_valid_s1 <= 1'b1;
		end else if (push_ready) begin
			tok_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1.data_byte <= stream.data_byte;
			tok_s1.end_of_input <= stream.end_of_input;
			tok_s1.cls <= cls;
		end
	end
endmodule

>>> rtl/cldf_queue.sv
module cldf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  cldf_pkg::cldf_token_t push_data,
	output logic                  push_ready,
	output logic                  pop_valid,
	output cldf_pkg::cldf_token_t pop_data,
	input  logic                  pop_ready
);
	import cldf_pkg::*;

	cldf_token_t          slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_q;
	logic [QUEUE_AW-1:0]  rd_q;
	logic [QUEUE_AW:0]    count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = slots_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end
endmodule

>>> rtl/cldf_back.sv
module cldf_back #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_valid,
	input  cldf_pkg::cldf_token_t tok,
	output logic                  tok_ready,
	cldf_out_if.source            result
);
	import cldf_pkg::*;

	localparam logic [2:0] PH_LINE_START  = 3'd0;
	localparam logic [2:0] PH_NAME        = 3'd1;
	localparam logic [2:0] PH_AFTER_COLON = 3'd2;
	localparam logic [2:0] PH_VALUE       = 3'd3;
	localparam logic [2:0] PH_VALUE_LF    = 3'd4;
	localparam logic [2:0] PH_BLANK_LF    = 3'd5;
	localparam logic [2:0] PH_PAYLOAD     = 3'd6;

	localparam logic [1:0] NUM_SKIP = 2'd0;
	localparam logic [1:0] NUM_POS  = 2'd1;
	localparam logic [1:0] NUM_NEG  = 2'd2;
	localparam logic [1:0] NUM_DONE = 2'd3;

	localparam int WIDE_BITS = LENGTH_BITS + 4;

	logic [2:0]             phase_q, phase_d;
	logic [3:0]             pos_q, pos_d;
	logic                   is_len_q, is_len_d;
	logic                   is_type_q, is_type_d;
	logic                   space_q, space_d;
	logic [1:0]             num_q, num_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic                   seen_q, seen_d;
	logic [LENGTH_BITS-1:0] plen_q, plen_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;

	logic                   res_valid;
	logic [1:0]             res_kind;
	logic [7:0]             res_byte;
	logic                   res_last;
	logic [2:0]             res_err;

	logic                   new_line;
	logic                   new_message;
	logic                   skip_byte;
	logic [WIDE_BITS-1:0]   wide;
	logic [LENGTH_BITS-1:0] acc_next;

	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [7:0]             out_byte_q;
	logic                   out_last_q;
	logic [2:0]             out_err_q;

	assign tok_ready = !out_valid_q || result.ready;

	// times ten plus digit, saturating
	always_comb begin
		wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ WIDE_BITS'(tok.data_byte - "0");
		if (wide[WIDE_BITS-1:LENGTH_BITS] != '0) begin
			acc_next = '1;
		end else begin
			acc_next = wide[LENGTH_BITS-1:0];
		end
	end

	// parse one byte
	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		is_len_d = is_len_q;
		is_type_d = is_type_q;
		space_d = space_q;
		num_d = num_q;
		acc_d = acc_q;
		seen_d = seen_q;
		plen_d = plen_q;
		remain_d = remain_q;
		res_valid = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_byte = 8'h00;
		res_last = 1'b0;
		res_err = ERR_NONE;
		new_line = 1'b0;
		new_message = 1'b0;
		skip_byte = 1'b0;

		case (phase_q)
			PH_LINE_START, PH_NAME: begin
				if (tok.end_of_input) begin
					res_valid = 1'b1;
					res_err = ERR_EARLY_END;
				end else if (phase_q == PH_LINE_START && tok.cls.cr) begin
					phase_d = PH_BLANK_LF;
				end else if (tok.cls.colon) begin
					is_len_d = is_len_q && pos_q == LENGTH_NAME_LEN;
					is_type_d = is_type_q && pos_q == TYPE_NAME_LEN;
					phase_d = PH_AFTER_COLON;
				end else if (!tok.cls.name_char) begin
					res_valid = 1'b1;
					res_err = ERR_NAME_CHAR;
				end else begin
					phase_d = PH_NAME;
					if (pos_q >= LENGTH_NAME_LEN || length_char(pos_q) != tok.data_byte) begin
						is_len_d = 1'b0;
					end
					if (pos_q >= TYPE_NAME_LEN || type_char(pos_q) != tok.data_byte) begin
						is_type_d = 1'b0;
					end
					if (pos_q < NAME_POS_MAX) begin
						pos_d = pos_q + 1'b1;
					end
				end
			end
			PH_AFTER_COLON: begin
				if (tok.end_of_input) begin
					res_valid = 1'b1;
					res_err = ERR_EARLY_END;
				end else begin
					space_d = tok.cls.space;
					phase_d = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (tok.end_of_input) begin
					res_valid = 1'b1;
					res_err = ERR_EARLY_END;
				end else if (tok.cls.cr) begin
					phase_d = PH_VALUE_LF;
				end else begin
					// leading blanks and sign
					if (num_q == NUM_SKIP) begin
						if (tok.cls.blank) begin
							skip_byte = 1'b1;
						end else if (tok.cls.plus) begin
							num_d = NUM_POS;
							skip_byte = 1'b1;
						end else if (tok.cls.minus) begin
							num_d = NUM_NEG;
							skip_byte = 1'b1;
						end else begin
							num_d = NUM_POS;
						end
					end
					if (!skip_byte && num_q != NUM_DONE) begin
						if (!tok.cls.digit) begin
							num_d = NUM_DONE;
						end else if (num_q != NUM_NEG) begin
							acc_d = acc_next;
						end
					end
				end
			end
			PH_VALUE_LF: begin
				if (tok.end_of_input || !tok.cls.lf) begin
					res_valid = 1'b1;
					res_err = ERR_VALUE_LF;
				end else if (space_q && is_len_q) begin
					plen_d = (num_q == NUM_NEG) ? '0 : acc_q;
					seen_d = 1'b1;
					new_line = 1'b1;
				end else if (!(space_q && is_type_q)) begin
					res_valid = 1'b1;
					res_err = ERR_UNKNOWN;
				end else begin
					new_line = 1'b1;
				end
			end
			PH_BLANK_LF: begin
				if (tok.end_of_input || !tok.cls.lf) begin
					res_valid = 1'b1;
					res_err = ERR_BLANK_LF;
				end else if (!seen_q) begin
					res_valid = 1'b1;
					res_err = ERR_NO_LENGTH;
				end else if (plen_q == '0) begin
					new_message = 1'b1;
					res_valid = 1'b1;
					res_kind = KIND_EMPTY;
					res_last = 1'b1;
				end else begin
					remain_d = plen_q;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (tok.end_of_input) begin
					res_valid = 1'b1;
					res_err = ERR_EARLY_END;
				end else begin
					res_valid = 1'b1;
					res_byte = tok.data_byte;
					if (remain_q <= LENGTH_BITS'(1)) begin
						new_message = 1'b1;
						res_last = 1'b1;
					end else begin
						remain_d = remain_q - 1'b1;
					end
				end
			end
			default: begin
				new_message = 1'b1;
			end
		endcase

		// any error drops the whole message
		if (res_err != ERR_NONE) begin
			res_kind = KIND_ERROR;
			new_message = 1'b1;
		end
		if (new_message || new_line) begin
			phase_d = PH_LINE_START;
			pos_d = '0;
			is_len_d = 1'b1;
			is_type_d = 1'b1;
			space_d = 1'b0;
			num_d = NUM_SKIP;
			acc_d = '0;
		end
		if (new_message) begin
			seen_d = 1'b0;
			plen_d = '0;
			remain_d = '0;
		end
	end

	// advance parser state on each consumed token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			pos_q <= '0;
			is_len_q <= 1'b1;
			is_type_q <= 1'b1;
			space_q <= 1'b0;
			num_q <= NUM_SKIP;
			acc_q <= '0;
			seen_q <= 1'b0;
			plen_q <= '0;
			remain_q <= '0;
		end else if (tok_valid && tok_ready) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			is_len_q <= is_len_d;
			is_type_q <= is_type_d;
			space_q <= space_d;
			num_q <= num_d;
			acc_q <= acc_d;
			seen_q <= seen_d;
			plen_q <= plen_d;
			remain_q <= remain_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_valid && tok_ready) begin
			out_valid_q <= res_valid;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid && tok_ready && res_valid) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_err_q <= res_err;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = out_kind_q;
	assign result.payload_byte = out_byte_q;
	assign result.last_of_message = out_last_q;
	assign result.error_code = out_err_q;
endmodule

>>> rtl/content_length_message_deframer_core.sv
// Content-Length deframer: takes one stream byte (or an end-of-input mark) per
// transfer, parses "Name: value" CRLF header lines, and after the blank line
// passes exactly Content-Length payload bytes, marking the last one; a zero
// length gives one empty-message result, and any framing fault gives an error
// result and restarts parsing at the next byte. The block sustains one byte
// per clock cycle while the result side is ready; the back-end parser does
// its state step and the times-ten length accumulate in one update. A byte
// passes a classify register, a four-entry queue and the back-end parser, and
// its result is offered from the result register.
// LENGTH_BITS sets the width of the length and byte counters; larger lengths
// saturate.
module content_length_message_deframer_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	cldf_in_if.sink     stream,
	cldf_out_if.source  result
);
	import cldf_pkg::*;

	cldf_token_t tok_s1;
	logic        tok_valid_s1;
	logic        push_ready;
	cldf_token_t head;
	logic        head_valid;
	logic        head_ready;

	cldf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream       (stream),
		.tok_s1       (tok_s1),
		.tok_valid_s1 (tok_valid_s1),
		.push_ready   (push_ready)
	);

	cldf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (tok_valid_s1),
		.push_data  (tok_s1),
		.push_ready (push_ready),
		.pop_valid  (head_valid),
		.pop_data   (head),
		.pop_ready  (head_ready)
	);

	cldf_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (head_valid),
		.tok       (head),
		.tok_ready (head_ready),
		.result    (result)
	);
endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cldf_pkg::*;

	localparam int LENGTH_BITS = 32;
	localparam longint unsigned LENGTH_MAX = ((64'd1 << (LENGTH_BITS - 1)) << 1) - 64'd1;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_BYTES = 300;
	localparam int HOLD_OFF_CYCLES = 250;

	typedef enum logic [2:0] {
		AT_LINE_START,
		IN_NAME,
		AFTER_COLON,
		IN_VALUE,
		WANT_VALUE_LF,
		WANT_BLANK_LF,
		IN_PAYLOAD
	} parse_phase_e;

	typedef enum logic [1:0] {
		SIGN_SKIP,
		SIGN_PLUS,
		SIGN_MINUS,
		SIGN_DONE
	} sign_phase_e;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic       last_of_message;
		logic [2:0] error_code;
	} deframed_t;

	logic clk;
	logic arst_n;

	cldf_in_if  stream_if();
	cldf_out_if result_if();

	content_length_message_deframer_core #(.LENGTH_BITS(LENGTH_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	// parser state mirrored for prediction
	parse_phase_e      hdr_phase;
	logic [3:0]        name_pos;
	logic              could_be_length;
	logic              could_be_type;
	logic              space_seen;
	sign_phase_e       sign_phase;
	longint unsigned   digits_value;
	logic              length_known;
	longint unsigned   frame_length;
	longint unsigned   bytes_left;

	string length_name = "Content-Length";
	string type_name = "Content-Type";

	deframed_t   deframed_due[$];
	logic [7:0]  frame_q[$];
	int          fault_count = 0;
	int          items_sent = 0;
	int          sink_hold_req = 0;
	bit          source_gaps_on = 1'b1;
	bit          sink_stalls_on = 1'b1;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic void clear_line();
		hdr_phase = AT_LINE_START;
		name_pos = '0;
		could_be_length = 1'b1;
		could_be_type = 1'b1;
		space_seen = 1'b0;
		sign_phase = SIGN_SKIP;
		digits_value = 0;
	endfunction

	function automatic void clear_message();
		clear_line();
		length_known = 1'b0;
		frame_length = 0;
		bytes_left = 0;
	endfunction

	function automatic deframed_t framing_error(input logic [2:0] code);
		clear_message();
		return '{kind: KIND_ERROR, payload_byte: 8'h00, last_of_message: 1'b0, error_code: code};
	endfunction

	// advance the mirrored parser by one transfer; return 1 when it yields a result
	function automatic bit deframe_byte(input logic [7:0] c, input logic eoi,
		output deframed_t r);
		logic            blank;
		logic            digit;
		logic            letter;
		logic            skip;
		longint unsigned dval;
		r = '0;
		blank = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) ||
			(c == CHR_VT) || (c == CHR_FF);
		digit = (c >= "0") && (c <= "9");
		letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
		case (hdr_phase)
			AT_LINE_START, IN_NAME: begin
				if (eoi) begin
					r = framing_error(ERR_EARLY_END);
					return 1'b1;
				end
				if (hdr_phase == AT_LINE_START && c == CHR_CR) begin
					hdr_phase = WANT_BLANK_LF;
					return 1'b0;
				end
				hdr_phase = IN_NAME;
				if (c == CHR_COLON) begin
					could_be_length = could_be_length && (name_pos == LENGTH_NAME_LEN);
					could_be_type = could_be_type && (name_pos == TYPE_NAME_LEN);
					hdr_phase = AFTER_COLON;
					return 1'b0;
				end
				if (!letter && c != CHR_DASH) begin
					r = framing_error(ERR_NAME_CHAR);
					return 1'b1;
				end
				if (name_pos >= LENGTH_NAME_LEN || length_name[name_pos] != c)
					could_be_length = 1'b0;
				if (name_pos >= TYPE_NAME_LEN || type_name[name_pos] != c)
					could_be_type = 1'b0;
				if (name_pos < NAME_POS_MAX)
					name_pos++;
				return 1'b0;
			end
			AFTER_COLON: begin
				if (eoi) begin
					r = framing_error(ERR_EARLY_END);
					return 1'b1;
				end
				space_seen = (c == CHR_SPACE);
				hdr_phase = IN_VALUE;
				return 1'b0;
			end
			IN_VALUE: begin
				if (eoi) begin
					r = framing_error(ERR_EARLY_END);
					return 1'b1;
				end
				if (c == CHR_CR) begin
					hdr_phase = WANT_VALUE_LF;
					return 1'b0;
				end
				// decimal decode: blanks, sign, then digits until the first non-digit
				skip = 1'b0;
				if (sign_phase == SIGN_SKIP) begin
					if (blank)
						skip = 1'b1;
					else if (c == CHR_PLUS) begin
						sign_phase = SIGN_PLUS;
						skip = 1'b1;
					end else if (c == CHR_DASH) begin
						sign_phase = SIGN_MINUS;
						skip = 1'b1;
					end else
						sign_phase = SIGN_PLUS;
				end
				if (!skip && sign_phase != SIGN_DONE) begin
					if (!digit)
						sign_phase = SIGN_DONE;
					else if (sign_phase == SIGN_PLUS) begin
						dval = longint'(c - 8'h30);
						if (digits_value > (LENGTH_MAX - dval) / 10)
							digits_value = LENGTH_MAX;
						else
							digits_value = digits_value * 10 + dval;
					end
				end
				return 1'b0;
			end
			WANT_VALUE_LF: begin
				if (eoi || c != CHR_LF) begin
					r = framing_error(ERR_VALUE_LF);
					return 1'b1;
				end
				if (space_seen && could_be_length) begin
					frame_length = (sign_phase == SIGN_MINUS) ? 64'd0 : (digits_value & LENGTH_MAX);
					length_known = 1'b1;
				end else if (!(space_seen && could_be_type)) begin
					r = framing_error(ERR_UNKNOWN);
					return 1'b1;
				end
				clear_line();
				return 1'b0;
			end
			WANT_BLANK_LF: begin
				if (eoi || c != CHR_LF) begin
					r = framing_error(ERR_BLANK_LF);
					return 1'b1;
				end
				if (!length_known) begin
					r = framing_error(ERR_NO_LENGTH);
					return 1'b1;
				end
				if (frame_length == 0) begin
					clear_message();
					r = '{kind: KIND_EMPTY, payload_byte: 8'h00, last_of_message: 1'b1,
						error_code: ERR_NONE};
					return 1'b1;
				end
				bytes_left = frame_length;
				hdr_phase = IN_PAYLOAD;
				return 1'b0;
			end
			IN_PAYLOAD: begin
				if (eoi) begin
					r = framing_error(ERR_EARLY_END);
					return 1'b1;
				end
				r = '{kind: KIND_PAYLOAD, payload_byte: c, last_of_message: 1'b0,
					error_code: ERR_NONE};
				if (bytes_left <= 1) begin
					clear_message();
					r.last_of_message = 1'b1;
				end else
					bytes_left--;
				return 1'b1;
			end
			default: begin
				clear_message();
				return 1'b0;
			end
		endcase
	endfunction

	// predict on every input transfer
	always @(posedge clk) begin : track_input
		deframed_t r;
		if (arst_n && stream_if.valid && stream_if.ready) begin
			if (deframe_byte(stream_if.data_byte, stream_if.end_of_input, r))
				deframed_due = {deframed_due, r};
		end
	end

	// compare every output transfer with the oldest prediction
	always @(posedge clk) begin : check_result
		deframed_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (deframed_due.size() == 0) begin
				$error("unexpected result: kind %0d byte %02h last %0b code %0d",
					result_if.kind, result_if.payload_byte, result_if.last_of_message,
					result_if.error_code);
				fault_count++;
			end else begin
				want = deframed_due.pop_front();
				if (result_if.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result_if.kind);
					fault_count++;
				end
				if (result_if.payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h", want.payload_byte,
						result_if.payload_byte);
					fault_count++;
				end
				if (result_if.last_of_message !== want.last_of_message) begin
					$error("last_of_message: expected %0b, got %0b", want.last_of_message,
						result_if.last_of_message);
					fault_count++;
				end
				if (result_if.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						result_if.error_code);
					fault_count++;
				end
			end
		end
	end

	// drive the result side: random stalls plus a requested long hold-off
	initial begin : drive_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				hold_left = sink_hold_req;
				sink_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (sink_stalls_on && $urandom_range(0, 3) == 0)
					stall_left = idle_span();
			end
		end
	end

	// end the run when no transfer happens for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else if (arst_n)
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// offer one transfer, after an optional gap, and hold it until taken
	task automatic send_item(input logic [7:0] b, input logic eoi);
		int gap;
		gap = source_gaps_on ? idle_span() : 0;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			stream_if.data_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.data_byte <= b;
		stream_if.end_of_input <= eoi;
		do @(posedge clk); while (!stream_if.ready);
		items_sent++;
	endtask

	task automatic send_end();
		send_item(8'($urandom), 1'b1);
	endtask

	function automatic void add_byte(input logic [7:0] b);
		frame_q = {frame_q, b};
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void add_crlf();
		add_byte(CHR_CR);
		add_byte(CHR_LF);
	endfunction

	task automatic send_frame();
		foreach (frame_q[i])
			send_item(frame_q[i], 1'b0);
		frame_q.delete();
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_frame();
	endtask

	task automatic send_line(input string s);
		add_text(s);
		add_crlf();
		send_frame();
	endtask

	// close the input and let every predicted result come out
	task automatic drain_results();
		stream_if.valid <= 1'b0;
		@(posedge clk);
		while (deframed_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void add_type_line();
		logic [7:0] b;
		add_text("Content-Type: ");
		repeat ($urandom_range(0, 10)) begin
			do b = 8'($urandom); while (b == CHR_CR);
			add_byte(b);
		end
		add_crlf();
	endfunction

	// well-formed frame: stale headers first, the real length last, random payload
	function automatic void add_random_frame();
		logic [7:0] blanks[5] = '{CHR_SPACE, CHR_TAB, CHR_LF, CHR_VT, CHR_FF};
		int pay_len;
		int extra;
		pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
		extra = $urandom_range(0, 2);
		for (int i = 0; i < extra; i++) begin
			if ($urandom_range(0, 1))
				add_type_line();
			else begin
				add_text($sformatf("Content-Length: %0d", $urandom_range(0, 99999)));
				add_crlf();
			end
		end
		add_text("Content-Length: ");
		case ($urandom_range(0, 5))
			0: add_text($sformatf("%0d", pay_len));
			1: begin
				repeat ($urandom_range(1, 3)) add_byte(blanks[$urandom_range(0, 4)]);
				add_text($sformatf("%0d", pay_len));
			end
			2: add_text($sformatf("+%0d", pay_len));
			3: add_text($sformatf("%0d z7", pay_len));
			4: add_text($sformatf("000%0d", pay_len));
			default: begin
				pay_len = 0;
				if ($urandom_range(0, 1))
					add_text($sformatf("-%0d", $urandom_range(1, 500)));
				else
					add_text("none");
			end
		endcase
		add_crlf();
		if ($urandom_range(0, 3) == 0)
			add_type_line();
		add_crlf();
		repeat (pay_len) add_byte(8'($urandom));
	endfunction

	// noise, cut or corrupted frames, always closed by an end mark to resync
	task automatic send_broken_sequence();
		int cut;
		int pos;
		case ($urandom_range(0, 4))
			0: repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
			1: begin
				add_random_frame();
				cut = $urandom_range(1, frame_q.size());
				frame_q = frame_q[0:cut-1];
			end
			2: begin
				add_random_frame();
				pos = $urandom_range(0, frame_q.size() - 1);
				frame_q[pos] = 8'($urandom);
			end
			3: begin
				add_type_line();
				if ($urandom_range(0, 1)) begin
					add_text("X-Trace: 1");
					add_crlf();
				end
				add_crlf();
			end
			default: ;
		endcase
		send_frame();
		send_end();
	endtask

	// empty message, payload with NUL and 0xFF, end mark after a message
	task automatic test_frame_basics();
		send_line("Content-Length: 0");
		send_line("");
		send_line("Content-Type: text/plain");
		send_line("Content-Length: 3");
		send_line("");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte("A");
		send_frame();
		send_end();
		drain_results();
	endtask

	// blanks and signs, negative, junk after digits, overflow, last length wins
	task automatic test_length_values();
		add_text("Content-Length: ");
		add_byte(CHR_TAB);
		add_byte(CHR_VT);
		add_byte(CHR_FF);
		add_byte(CHR_LF);
		add_text(" +2");
		add_crlf();
		add_crlf();
		add_text("ok");
		send_frame();
		send_line("Content-Length: -7");
		send_line("");
		send_line("Content-Length: 1x9");
		send_line("");
		send_text("z");
		send_line("Content-Length: zz");
		send_line("");
		send_line("Content-Length: 99999999999");
		send_line("Content-Length: 1");
		send_line("");
		send_text("Q");
		send_line("Content-Length: 4294967296");
		send_line("");
		send_text("ab");
		send_end();
		drain_results();
	endtask

	// every framing fault and early end in each header phase
	task automatic test_header_faults();
		send_line("Content-length: 1");
		send_line(": 1");
		send_line("Content-Length:5");
		send_line("Content-Type:x");
		send_line("Content-Lengthh: 1");
		send_line("Content-Typ: a");
		send_line("ABCDEFGHIJKLMNOPQRS: 2");
		add_text("Cont");
		add_byte(8'h00);
		add_text("X");
		add_byte(8'hFF);
		add_text("a1");
		send_frame();
		add_text("Content-Length: 1");
		add_byte(CHR_CR);
		add_text("X");
		send_frame();
		add_text("Content-Length: 1");
		add_byte(CHR_CR);
		send_frame();
		send_end();
		add_byte(CHR_CR);
		add_text("Y");
		add_byte(CHR_CR);
		send_frame();
		send_end();
		send_line("");
		send_line("Content-Type: a");
		send_line("");
		send_end();
		send_text("Con");
		send_end();
		send_text("A:");
		send_end();
		send_text("Content-Type: x");
		send_end();
		drain_results();
	endtask

	// hold the result side off while a long payload keeps coming
	task automatic test_output_backpressure();
		source_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		sink_hold_req = HOLD_OFF_CYCLES;
		send_line("Content-Length: 48");
		send_line("");
		repeat (48) add_byte(8'($urandom));
		send_frame();
		drain_results();
	endtask

	// mostly well-formed frames with random content, some noise
	task automatic test_random_traffic();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_BYTES) begin
			source_gaps_on = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0)
				send_broken_sequence();
			else begin
				add_random_frame();
				send_frame();
			end
		end
		drain_results();
	endtask

	initial begin
		clear_message();
		stream_if.valid <= 1'b0;
		stream_if.data_byte <= 8'h00;
		stream_if.end_of_input <= 1'b0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frame_basics();
		test_length_values();
		test_header_faults();
		test_output_backpressure();
		test_random_traffic();
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
rtl/cldf_pkg.sv
rtl/cldf_ifs.sv
rtl/cldf_front.sv
rtl/cldf_queue.sv
rtl/cldf_back.sv
rtl/content_length_message_deframer_core.sv
bench/tb_top.sv
